// ----- rtl/cartesian_to_polar_with_peak_defines.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef CARTESIAN_TO_POLAR_WITH_PEAK_DEFINES_SVH
`define CARTESIAN_TO_POLAR_WITH_PEAK_DEFINES_SVH

// Concurrent check on an explicit clock and active-low reset.
`define C2P_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block clock and reset.
`define C2P_ASSERT(label, prop, msg) \
  `C2P_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/c2p_pkg.sv -----
package c2p_pkg;

  localparam int unsigned SAMPLE_BITS_DEF   = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned GUARD_BITS        = 16;
  localparam int unsigned MAG_BITS          = 16;
  localparam int unsigned ANGLE_BITS        = 16;
  localparam int unsigned Z_BITS            = 32;

  localparam logic [31:0] GAIN_Q32   = 32'd2608131496;
  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [31:0] ANGLE_HALF = 32'h0000_8000;

  // atan(2^-i) scaled so that 2^31 is pi
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef struct packed {
    logic valid;
    logic zero;
    logic last;
  } c2p_ctrl_t;

endpackage

// ----- rtl/c2p_if.sv -----
interface c2p_in_if import c2p_pkg::*; #(
  parameter int unsigned SampleBits = SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] in_re;
  logic signed [SampleBits-1:0] in_im;
  logic                         in_last;

  modport source (output valid, output in_re, output in_im, output in_last, input ready);
  modport sink   (input valid, input in_re, input in_im, input in_last, output ready);
endinterface

interface c2p_out_if import c2p_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic        [MAG_BITS-1:0]   magnitude;
  logic signed [ANGLE_BITS-1:0] angle;
  logic        [MAG_BITS-1:0]   peak_so_far;
  logic                         out_last;

  modport source (output valid, output magnitude, output angle, output peak_so_far,
                  output out_last, input ready);
  modport sink   (input valid, input magnitude, input angle, input peak_so_far,
                  input out_last, output ready);
endinterface

// ----- rtl/cartesian_to_polar_with_peak.sv -----
// Channel  Dir  Payload                                        Transfer
// in_i     in   in_re, in_im (SAMPLE_BITS, signed), in_last    valid && ready
// out_o    out  magnitude, angle, peak_so_far (16), out_last   valid && ready
//
// One sample enters per cycle while the pipe is not stalled; the stages are the input
// register, one cell per micro-rotation, two gain stages and the output register.
// The whole pipe advances on a single enable: it stalls only while the output
// register holds a result that is not taken; in_i.ready carries that enable.
// Reset clears valid bits and the running peak; payload registers are not reset.
// Bubbles travel down the pipe in place; the peak updates only on valid results.
`include "cartesian_to_polar_with_peak_defines.svh"

module cartesian_to_polar_with_peak import c2p_pkg::*; #(
  parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  c2p_in_if.sink    in_i,
  c2p_out_if.source out_o
);

  // datapath width: guard bits plus headroom for CORDIC growth and sqrt(2)
  localparam int unsigned W = SAMPLE_BITS + GUARD_BITS + 2;

  logic en;

  // ---------------------------------------------------------------
  // Pre-rotation: move the sample into the right half plane.
  // ---------------------------------------------------------------
  logic signed [W-1:0] re_w, im_w;
  logic signed [W-1:0] x0_d, y0_d, x0_q, y0_q;
  logic [Z_BITS-1:0]   z0_d, z0_q;
  c2p_ctrl_t           ctrl0_d, ctrl0_q;

  assign re_w = W'(in_i.in_re) <<< GUARD_BITS;
  assign im_w = W'(in_i.in_im) <<< GUARD_BITS;

  always_comb begin
    ctrl0_d.valid = in_i.valid;
    ctrl0_d.zero  = (in_i.in_re == '0) && (in_i.in_im == '0);
    ctrl0_d.last  = in_i.in_last;
    if (re_w[W-1]) begin
      x0_d = -re_w;
      y0_d = -im_w;
      z0_d = HALF_TURN;
    end else begin
      x0_d = re_w;
      y0_d = im_w;
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl0_q <= '0;
    end else if (en) begin
      ctrl0_q <= ctrl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= x0_d;
      y0_q <= y0_d;
      z0_q <= z0_d;
    end
  end

  // ---------------------------------------------------------------
  // Chain of micro-rotation cells.
  // ---------------------------------------------------------------
  c2p_ctrl_t           ctrl_s [CORDIC_STAGES+1];
  logic signed [W-1:0] x_s    [CORDIC_STAGES+1];
  logic signed [W-1:0] y_s    [CORDIC_STAGES+1];
  logic [Z_BITS-1:0]   z_s    [CORDIC_STAGES+1];

  assign ctrl_s[0] = ctrl0_q;
  assign x_s[0]    = x0_q;
  assign y_s[0]    = y0_q;
  assign z_s[0]    = z0_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    c2p_cell #(
      .W     (W),
      .STAGE (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl_s[g]),
      .x_i    (x_s[g]),
      .y_i    (y_s[g]),
      .z_i    (z_s[g]),
      .ctrl_o (ctrl_s[g+1]),
      .x_o    (x_s[g+1]),
      .y_o    (y_s[g+1]),
      .z_o    (z_s[g+1])
    );
  end

  // angle: accumulator rounded half up to its upper 16 bits; zero sample reads 0
  logic [Z_BITS-1:0]     z_rnd;
  logic [ANGLE_BITS-1:0] ang_end;

  assign z_rnd   = z_s[CORDIC_STAGES] + ANGLE_HALF;
  assign ang_end = ctrl_s[CORDIC_STAGES].zero ? '0 : z_rnd[Z_BITS-1 -: ANGLE_BITS];

  // ---------------------------------------------------------------
  // Gain compensation.
  // ---------------------------------------------------------------
  c2p_ctrl_t             g_ctrl;
  logic [MAG_BITS-1:0]   g_mag;
  logic [ANGLE_BITS-1:0] g_ang;

  c2p_gain #(
    .W (W)
  ) u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctrl_i (ctrl_s[CORDIC_STAGES]),
    .x_i    (x_s[CORDIC_STAGES]),
    .ang_i  (ang_end),
    .ctrl_o (g_ctrl),
    .mag_o  (g_mag),
    .ang_o  (g_ang)
  );

  // ---------------------------------------------------------------
  // Running peak and output register.
  // ---------------------------------------------------------------
  logic                  out_valid_q;
  logic [MAG_BITS-1:0]   mag_q, peak_out_q, peak_q, peak_d, peak_new;
  logic [ANGLE_BITS-1:0] ang_q;
  logic                  last_q;
  logic                  out_load;

  // the pipe moves whenever the output register is empty or being emptied
  assign en       = !out_valid_q || out_o.ready;
  assign out_load = en && g_ctrl.valid;

  assign peak_new = (g_mag > peak_q) ? g_mag : peak_q;
  // frame end: report the maximum, then start the next frame from zero
  assign peak_d   = g_ctrl.last ? '0 : peak_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      peak_q      <= '0;
    end else begin
      if (en) begin
        out_valid_q <= g_ctrl.valid;
      end
      if (out_load) begin
        peak_q <= peak_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mag_q      <= g_mag;
      ang_q      <= g_ang;
      peak_out_q <= peak_new;
      last_q     <= g_ctrl.last;
    end
  end

  assign in_i.ready        = en;
  assign out_o.valid       = out_valid_q;
  assign out_o.magnitude   = mag_q;
  assign out_o.angle       = ang_q;
  assign out_o.peak_so_far = peak_out_q;
  assign out_o.out_last    = last_q;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `C2P_ASSERT(a_stall_blocks_input, (out_o.valid && !out_o.ready) |-> !in_i.ready, "input in stall")
  `C2P_ASSERT(a_peak_covers_mag, out_o.valid |-> out_o.peak_so_far >= out_o.magnitude, "peak < mag")
  `C2P_ASSERT(a_peak_clears, (out_load && g_ctrl.last) |=> (peak_q == '0), "peak not cleared")
  `C2P_ASSERT(a_peak_tracks, (out_load && !g_ctrl.last) |=> peak_q == out_o.peak_so_far, "peak skew")

endmodule

// ----- rtl/c2p_cell.sv -----
// One CORDIC vectoring micro-rotation, registered.
module c2p_cell import c2p_pkg::*; #(
  parameter int unsigned W     = 34,
  parameter int unsigned STAGE = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  c2p_ctrl_t           ctrl_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic [Z_BITS-1:0]   z_i,
  output c2p_ctrl_t           ctrl_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic [Z_BITS-1:0]   z_o
);

  c2p_ctrl_t           ctrl_q;
  logic signed [W-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic [Z_BITS-1:0]   z_q, z_d;

  assign dx = y_i >>> STAGE;
  assign dy = x_i >>> STAGE;

  always_comb begin
    if (!y_i[W-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN_TAB[STAGE];
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ----- rtl/c2p_gain.sv -----
// CORDIC gain compensation: two 32x32 partial products, then sum, round, saturate; a zero sample reads 0.
module c2p_gain import c2p_pkg::*; #(
  parameter int unsigned W = 34
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  c2p_ctrl_t             ctrl_i,
  input  logic signed [W-1:0]   x_i,
  input  logic [ANGLE_BITS-1:0] ang_i,
  output c2p_ctrl_t             ctrl_o,
  output logic [MAG_BITS-1:0]   mag_o,
  output logic [ANGLE_BITS-1:0] ang_o
);

  c2p_ctrl_t             ctrl1_q, ctrl2_q;
  logic [63:0]           ux;
  logic [63:0]           lo_g_q, hi_g_q;
  logic [63:0]           prod, rnd;
  logic [MAG_BITS-1:0]   mag_d, mag_q;
  logic [ANGLE_BITS-1:0] ang1_q, ang2_q;

  // x is never negative after vectoring
  assign ux = 64'(x_i);

  // x*G >> 32 split as hi*G + (lo*G >> 32)
  assign prod = hi_g_q + (lo_g_q >> 32);
  assign rnd  = prod + 64'(1 << (GUARD_BITS - 1));

  always_comb begin
    if (ctrl1_q.zero) begin
      mag_d = '0;
    end else if (|rnd[63:GUARD_BITS+MAG_BITS]) begin
      mag_d = '1;
    end else begin
      mag_d = rnd[GUARD_BITS +: MAG_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
    end else if (en_i) begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_g_q <= 64'(ux[31:0]) * 64'(GAIN_Q32);
      hi_g_q <= 64'(ux[63:32]) * 64'(GAIN_Q32);
      ang1_q <= ang_i;
      mag_q  <= mag_d;
      ang2_q <= ang1_q;
    end
  end

  assign ctrl_o = ctrl2_q;
  assign mag_o  = mag_q;
  assign ang_o  = ang2_q;

endmodule
